// ----- hdl/tceq_pkg.sv -----
// Shared types and constants for the touch event coalescing queue.
`timescale 1ns / 1ps

package tceq_pkg;

  // Touch action codes, as carried on both streams
  localparam logic [1:0] ActDown   = 2'd0;
  localparam logic [1:0] ActUp     = 2'd1;
  localparam logic [1:0] ActMove   = 2'd2;
  localparam logic [1:0] ActCancel = 2'd3;

  // Stream operation codes
  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] RegPanLeft      = 2'd0;
  localparam logic [1:0] RegPanWidth     = 2'd1;
  localparam logic [1:0] RegPanelTop     = 2'd2;
  localparam logic [1:0] RegScreenHeight = 2'd3;

  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned IdW     = 8;
  localparam int unsigned ActW    = 2;
  localparam int unsigned XW      = 12;
  localparam int unsigned YW      = 13;
  localparam int unsigned ScrW    = 17;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // Shared multiplier operand and product widths
  localparam int unsigned MulW  = 19;
  localparam int unsigned ProdW = 2 * MulW;

  // ceil(2^20 / 3): floor(q * Recip3 / 2^20) equals floor(q / 3) for q below 2^19
  localparam int unsigned Recip3Shift = 20;
  localparam logic [MulW-1:0] Recip3 = 19'd349526;

  localparam logic [ScrW-1:0] ScreenMax = 17'd131071;

  typedef struct packed {
    logic [YW-1:0]   y;
    logic [XW-1:0]   x;
    logic [ActW-1:0] action;
    logic [IdW-1:0]  id;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StPush,
    StRead,
    StMulX,
    StMulY,
    StDiv,
    StFin
  } state_e;

endpackage

// ----- hdl/tceq_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module tceq_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/touch_event_coalescing_queue.sv -----
// Top level of the touch event coalescing queue: sequencer, pointers and mapping datapath.
`timescale 1ns / 1ps
// Usage:
// - Slave stream carries one request per transfer: tuser selects push (0) or pop (1),
//   tdata carries the pushed event. Pushes give no result; every pop gives exactly one
//   result transfer on the master stream.
// - A push is accepted, then the memory write and pointer update follow in StPush.
// - A pop runs from accept to the result register through a memory read of the head,
//   then three passes through the one shared 19x19 multiplier (x times width, y times
//   span, divide by three by reciprocal), then the final add and saturate.
//   A pop of an empty queue skips straight to the result with pending low.
// - One request is in flight at a time; tready is high only while the sequencer idles.
// - The result sits in an output register. While the receiver stalls, further pushes are
//   still taken; a pop holds in its last step until the output register frees up.
// - Configuration is a plain write port; the user must write it only while the block is idle (not enforced).
// - Reset empties the queue and loads the default pan rectangle. The event memory is not
//   cleared: only entries already written are ever read.

module touch_event_coalescing_queue
  import tceq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // pointer_id, touch_action, pos_x, pos_y, zero pad
  input  logic                s_axis_tuser,  // op
  // Master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // out_id, out_action, screen_x, screen_y, zero pad
  output logic                m_axis_tuser,  // pending
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(QUEUE_DEPTH - 1);

  state_e state_q, state_d;

  // Configuration registers
  logic [CfgW-1:0] pan_left_q, pan_width_q, panel_top_q, screen_height_q;

  // Queue pointers
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdW-1:0]  tail_id_q, tail_id_d;
  logic [ActW-1:0] tail_act_q, tail_act_d;

  // Captured request
  logic   op_q;
  entry_t req_q;
  logic   pend_q;

  // Shared multiplier
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod_q, prod_d;
  logic             prod_en;

  // Mapped coordinates
  logic [ScrW-1:0] sx_q, sx_d;
  logic [ScrW:0]   sy_sum;
  logic [ScrW-1:0] sy_sat;
  logic [CfgW-1:0] span;

  // Memory ports
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata, ram_rdata;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic                out_pend_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_load;

  // Ring arithmetic
  logic [SumW-1:0] slot_sum;
  logic [IdxW-1:0] slot_idx, tail_idx, head_inc;
  logic            accept, is_coalesce;

  assign accept = s_axis_tvalid && s_axis_tready;

  assign slot_sum = SumW'(head_q) + SumW'(count_q);
  assign slot_idx = (slot_sum >= DepthSum) ? IdxW'(slot_sum - DepthSum) : IdxW'(slot_sum);
  assign tail_idx = (slot_idx == '0) ? LastIdx : slot_idx - 1'b1;
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  assign is_coalesce = (req_q.action == ActMove) && (count_q != '0) &&
                       (tail_act_q == ActMove) && (tail_id_q == req_q.id);

  assign span = (screen_height_q > panel_top_q) ? screen_height_q - panel_top_q : '0;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (s_axis_tuser == OpPush) begin
            state_d = StPush;
          end else if (count_q == '0) begin
            state_d = StFin;
          end else begin
            state_d = StRead;
          end
        end
      end
      StPush:  state_d = StIdle;
      StRead:  state_d = StMulX;
      StMulX:  state_d = StMulY;
      StMulY:  state_d = StDiv;
      StDiv:   state_d = StFin;
      StFin: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs: memory access, pointer update, multiplier operand selection
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    tail_id_d  = tail_id_q;
    tail_act_d = tail_act_q;
    ram_we     = 1'b0;
    ram_waddr  = slot_idx;
    ram_wdata  = req_q;
    ram_re     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    prod_en    = 1'b0;
    sx_d       = sx_q;
    out_load   = 1'b0;
    case (state_q)
      StPush: begin
        ram_we = 1'b1;
        if (op_q == OpPush && req_q.action != ActCancel && is_coalesce) begin
          // Overwrite the tail move with the new position
          ram_waddr = tail_idx;
        end else if (req_q.action != ActCancel && count_q < DepthCnt) begin
          ram_waddr  = slot_idx;
          count_d    = count_q + 1'b1;
          tail_id_d  = req_q.id;
          tail_act_d = req_q.action;
        end else begin
          // Cancel, or push into a full queue: collapse to a single cancel entry
          ram_waddr        = '0;
          ram_wdata.id     = req_q.id;
          ram_wdata.action = ActCancel;
          ram_wdata.x      = '0;
          ram_wdata.y      = '0;
          head_d           = '0;
          count_d          = CntW'(1);
          tail_id_d        = req_q.id;
          tail_act_d       = ActCancel;
        end
      end
      StRead: begin
        ram_re  = 1'b1;
        head_d  = head_inc;
        count_d = count_q - 1'b1;
      end
      StMulX: begin
        mul_a   = MulW'(ram_rdata.x);
        mul_b   = MulW'(pan_width_q);
        prod_en = 1'b1;
      end
      StMulY: begin
        sx_d    = ScrW'({pan_left_q, 4'b0000}) + ScrW'(prod_q[XW+CfgW-1:8]);
        mul_a   = MulW'(ram_rdata.y);
        mul_b   = MulW'(span);
        prod_en = 1'b1;
      end
      StDiv: begin
        // Divide by 64 as a shift, then by 3 through the reciprocal
        mul_a   = prod_q[YW+CfgW-1:6];
        mul_b   = Recip3;
        prod_en = 1'b1;
      end
      StFin: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  assign sy_sum = (ScrW + 1)'({panel_top_q, 4'b0000}) +
                  (ScrW + 1)'(prod_q[ProdW-1:Recip3Shift]);
  assign sy_sat = sy_sum[ScrW] ? ScreenMax : sy_sum[ScrW-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  tceq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      head_q          <= '0;
      count_q         <= '0;
      tail_id_q       <= '0;
      tail_act_q      <= ActDown;
      out_valid_q     <= 1'b0;
      pan_left_q      <= 12'd0;
      pan_width_q     <= 12'd256;
      panel_top_q     <= 12'd192;
      screen_height_q <= 12'd384;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      tail_id_q   <= tail_id_d;
      tail_act_q  <= tail_act_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegPanLeft:      pan_left_q      <= cfg_data_i;
          RegPanWidth:     pan_width_q     <= cfg_data_i;
          RegPanelTop:     panel_top_q     <= cfg_data_i;
          RegScreenHeight: screen_height_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      req_q  <= entry_t'(s_axis_tdata[$bits(entry_t)-1:0]);
      pend_q <= (count_q != '0);
    end
    if (prod_en) begin
      prod_q <= prod_d;
    end
    sx_q <= sx_d;
    if (out_load) begin
      out_pend_q <= pend_q;
      if (pend_q) begin
        out_data_q <= {4'b0000, sy_sat, sx_q, ram_rdata.action, ram_rdata.id};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_pend_q;

endmodule

// ----- tb/touch_event_coalescing_queue_tb.sv -----
// Self-checking testbench for the touch event coalescing queue.
`timescale 1ns / 1ps

module touch_event_coalescing_queue_tb
  import tceq_pkg::*;
();

  localparam int unsigned QDepth      = 64;
  localparam int unsigned SettleCycles = 24;      // covers a full pop with margin
  localparam int unsigned CycleLimit  = 600000;

  // One request on the slave stream
  typedef struct packed {
    logic   op;
    entry_t ev;
  } touch_req_t;

  // One frame pop as it should appear on the master stream
  typedef struct packed {
    logic            pending;
    logic [IdW-1:0]  id;
    logic [ActW-1:0] action;
    logic [ScrW-1:0] sx;
    logic [ScrW-1:0] sy;
  } mapped_event_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = OpPush;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = RegPanLeft;
  logic [CfgW-1:0]     cfg_data_i = '0;

  touch_event_coalescing_queue #(
    .QUEUE_DEPTH(QDepth)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the queue and the pan rectangle
  // ---------------------------------------------------------------------------
  entry_t          shadow_store [QDepth];
  logic [5:0]      shadow_head  = '0;
  int unsigned     shadow_count = 0;
  logic [CfgW-1:0] pan_left_q   = 12'd0;
  logic [CfgW-1:0] pan_width_q  = 12'd256;
  logic [CfgW-1:0] panel_top_q  = 12'd192;
  logic [CfgW-1:0] scr_height_q = 12'd384;

  touch_req_t    pending_reqs [$];   // requests not yet offered to the block
  mapped_event_t expected_pops [$];  // pop results still owed by the block
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  bit            src_idle_en    = 1'b1;
  bit            snk_idle_en    = 1'b1;

  // Drop everything and leave a lone cancel for this pointer at the head
  task automatic collapse_to_cancel(input logic [IdW-1:0] id);
    shadow_head     = '0;
    shadow_count    = 1;
    shadow_store[0] = '{y: '0, x: '0, action: ActCancel, id: id};
  endtask

  // Advance the shadow queue by one accepted request; owe a result for every pop
  task automatic apply_touch_request(input touch_req_t r);
    logic [5:0]      tail;
    logic [5:0]      slot;
    entry_t          e;
    mapped_event_t   res;
    longint unsigned span;
    longint unsigned sx;
    longint unsigned sy;
    tail = shadow_head + 6'(shadow_count) - 6'd1;
    slot = shadow_head + 6'(shadow_count);
    res  = '0;
    if (r.op == OpPush) begin
      if (r.ev.action == ActCancel) begin
        collapse_to_cancel(r.ev.id);
      end else if (r.ev.action == ActMove && shadow_count != 0 &&
                   shadow_store[tail].action == ActMove && shadow_store[tail].id == r.ev.id) begin
        // coalesce: a repeated move only refreshes the tail coordinates
        shadow_store[tail].x = r.ev.x;
        shadow_store[tail].y = r.ev.y;
      end else if (shadow_count < QDepth) begin
        shadow_store[slot] = r.ev;
        shadow_count++;
      end else begin
        collapse_to_cancel(r.ev.id);
      end
    end else begin
      if (shadow_count != 0) begin
        e    = shadow_store[shadow_head];
        span = (scr_height_q > panel_top_q) ? longint'(scr_height_q - panel_top_q) : 0;
        sx   = longint'(pan_left_q) * 16 + (longint'(e.x) * longint'(pan_width_q)) / 256;
        sy   = longint'(panel_top_q) * 16 + (longint'(e.y) * span) / 192;
        if (sx > ScreenMax) sx = ScreenMax;
        if (sy > ScreenMax) sy = ScreenMax;
        res.pending = 1'b1;
        res.id      = e.id;
        res.action  = e.action;
        res.sx      = ScrW'(sx);
        res.sy      = ScrW'(sy);
        shadow_head++;
        shadow_count--;
      end
      expected_pops.push_back(res);
    end
  endtask

  function automatic int unsigned draw_wait(input bit idle_en);
    if (!idle_en) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Slave side: offer queued requests, idle a random number of cycles between them
  // ---------------------------------------------------------------------------
  touch_req_t  in_flight;
  int unsigned src_wait = 0;

  always @(posedge clk_i) begin : src_drive
    bit         slot_free;
    touch_req_t nxt;
    if (rst_ni) begin
      slot_free = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_touch_request(in_flight);
        src_wait  = draw_wait(src_idle_en);
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt       = pending_reqs.pop_front();
          in_flight = nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.op;
          s_axis_tdata  <= {5'b0, nxt.ev.y, nxt.ev.x, nxt.ev.action, nxt.ev.id};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Master side: take each result, compare it, then stall a random while
  // ---------------------------------------------------------------------------
  int unsigned snk_wait = 0;

  always @(posedge clk_i) begin : result_check
    mapped_event_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pops.size() == 0) begin
          $error("result transfer with no pop outstanding");
          mismatch_count++;
        end else begin
          want = expected_pops.pop_front();
          check_field("pending",    want.pending, m_axis_tuser);
          check_field("out_id",     want.id,      m_axis_tdata[7:0]);
          check_field("out_action", want.action,  m_axis_tdata[9:8]);
          check_field("screen_x",   want.sx,      m_axis_tdata[26:10]);
          check_field("screen_y",   want.sy,      m_axis_tdata[43:27]);
        end
        snk_wait = draw_wait(snk_idle_en);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Give up if the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int unsigned stim_items = 0;

  task automatic push_touch(input int unsigned id, input logic [ActW-1:0] act,
                            input int unsigned x, input int unsigned y);
    touch_req_t r;
    r.op        = OpPush;
    r.ev.id     = IdW'(id);
    r.ev.action = act;
    r.ev.x      = XW'(x);
    r.ev.y      = YW'(y);
    pending_reqs.push_back(r);
    stim_items++;
  endtask

  task automatic pop_frame();
    touch_req_t r;
    r    = '0;
    r.op = OpPop;
    pending_reqs.push_back(r);
    stim_items++;
  endtask

  // Mostly a handful of fingers, now and then any id
  function automatic int unsigned pick_id();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 3);
    return $urandom_range(0, 255);
  endfunction

  function automatic int unsigned pick_x();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int unsigned pick_y();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 6143;
      default: return $urandom_range(0, 6143);
    endcase
  endfunction

  function automatic logic [ActW-1:0] pick_action();
    case ($urandom_range(0, 3))
      0:       return ActDown;
      1:       return ActUp;
      2:       return ActMove;
      default: return ActCancel;
    endcase
  endfunction

  // Sprinkle pops between the pushes of a gesture
  task automatic maybe_pop();
    if ($urandom_range(0, 99) < 35) pop_frame();
  endtask

  // A well-formed stroke: down, a run of moves (some from a second finger), up
  task automatic add_gesture();
    int unsigned id;
    int unsigned moves;
    id    = pick_id();
    moves = $urandom_range(0, 7);
    push_touch(id, ActDown, pick_x(), pick_y());
    maybe_pop();
    repeat (moves) begin
      if ($urandom_range(0, 5) == 0) push_touch(pick_id(), ActMove, pick_x(), pick_y());
      else push_touch(id, ActMove, pick_x(), pick_y());
      maybe_pop();
    end
    push_touch(id, ActUp, pick_x(), pick_y());
    maybe_pop();
  endtask

  // Overrun the queue with non-coalescing events so it collapses, then read some back
  task automatic add_overrun();
    repeat (QDepth + $urandom_range(1, 3)) begin
      push_touch(pick_id(), $urandom_range(0, 1) ? ActUp : ActDown, pick_x(), pick_y());
    end
    repeat ($urandom_range(1, 4)) pop_frame();
  endtask

  task automatic add_traffic(input int unsigned quota, input bit with_overrun);
    int unsigned stop_at;
    stop_at = stim_items + quota;
    if (with_overrun) add_overrun();
    while (stim_items < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: add_gesture();
        6:       repeat ($urandom_range(1, 6)) pop_frame();
        7:       push_touch(pick_id(), pick_action(), pick_x(), pick_y());
        8:       push_touch(pick_id(), ActCancel, pick_x(), pick_y());
        default: begin
          push_touch($urandom_range(0, 255), ActMove, pick_x(), pick_y());
          pop_frame();
        end
      endcase
    end
  endtask

  // Write all four pan registers, one per edge; only call while the block is idle
  task automatic write_pan_rect(input int unsigned left, input int unsigned width,
                                input int unsigned top, input int unsigned height);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegPanLeft;
    cfg_data_i  <= CfgW'(left);
    @(posedge clk_i);
    cfg_index_i <= RegPanWidth;
    cfg_data_i  <= CfgW'(width);
    @(posedge clk_i);
    cfg_index_i <= RegPanelTop;
    cfg_data_i  <= CfgW'(top);
    @(posedge clk_i);
    cfg_index_i <= RegScreenHeight;
    cfg_data_i  <= CfgW'(height);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pan_left_q   = CfgW'(left);
    pan_width_q  = CfgW'(width);
    panel_top_q  = CfgW'(top);
    scr_height_q = CfgW'(height);
  endtask

  // Hold until every request is taken and every pop answered, then let a push settle
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_pops.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, default pan rectangle
    pop_frame();                              // pop of an empty queue
    push_touch(0,   ActDown, 0,    0);
    push_touch(255, ActMove, 4095, 6143);     // largest id and x; y at 6143
    push_touch(255, ActMove, 1234, 0);        // same id move: coalesces into the tail
    push_touch(7,   ActMove, 2048, 4096);     // other id: appended
    push_touch(255, ActUp,   4095, 0);
    push_touch(128, ActDown, 1,    6143);
    repeat (5) pop_frame();
    pop_frame();                              // drained again
    push_touch(3,   ActMove, 100,  200);
    push_touch(200, ActCancel, 4095, 6143);   // clears; stored coordinates are zero
    push_touch(200, ActMove, 77,   88);       // tail is a cancel, so no coalescing
    push_touch(200, ActMove, 3000, 5000);     // coalesces
    repeat (3) pop_frame();
    wait_quiet();

    // Random part over several pan rectangles, extremes included
    write_pan_rect(0, 4095, 0, 4095);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    add_traffic(160, 1'b0);
    wait_quiet();

    write_pan_rect(4095, 4095, 4095, 0);      // top above height: span clamps to zero
    src_idle_en = 1'b0;
    snk_idle_en = 1'b1;
    add_traffic(160, 1'b1);
    wait_quiet();

    write_pan_rect(0, 0, 0, 0);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b0;
    add_traffic(160, 1'b0);
    wait_quiet();

    write_pan_rect($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    add_traffic(160, 1'b0);
    wait_quiet();

    write_pan_rect(100, 256, 192, 100);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    add_traffic(160, 1'b1);
    wait_quiet();

    write_pan_rect(0, 256, 192, 384);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    add_traffic(160, 1'b0);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
